### design/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

	typedef enum logic [2:0] {
		OP_PUT       = 3'd0,
		OP_SET_CUR   = 3'd1,
		OP_SHIFT_CUR = 3'd2,
		OP_SET_COL   = 3'd3,
		OP_RST_COL   = 3'd4,
		OP_CLEAR     = 3'd5,
		OP_SCROLL    = 3'd6,
		OP_READ      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		CK_GLYPH = 2'd0,
		CK_NL    = 2'd1,
		CK_CR    = 2'd2,
		CK_TAB   = 2'd3
	} char_kind_t;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] TAB_STEP = 8'd8;
	localparam logic [7:0] TAB_MASK = 8'hF8;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DFORE  = 2'd2;
	localparam logic [1:0] REG_DBACK  = 2'd3;

	localparam logic [6:0] RST_WIDTH  = 7'd40;
	localparam logic [4:0] RST_HEIGHT = 5'd10;
	localparam logic [7:0] RST_DFORE  = 8'd7;
	localparam logic [7:0] RST_DBACK  = 8'd0;

	typedef struct packed {
		op_t               op;
		char_kind_t        kind;
		logic [7:0]        char_code;
		logic [6:0]        col;
		logic [4:0]        row;
		logic signed [7:0] step_x;
		logic signed [7:0] step_y;
		logic [7:0]        fore;
		logic [7:0]        back;
		logic              take_fore;
		logic              take_back;
		logic [4:0]        scroll_lines;
	} cmd_t;

	typedef struct packed {
		logic [6:0] width_cols;
		logic [4:0] height_rows;
		logic [7:0] default_fore;
		logic [7:0] default_back;
	} cfg_t;

	typedef struct packed {
		logic ready;
		logic init;
	} bk_stat_t;

	typedef struct packed {
		logic       done;
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic [7:0] cur_fore;
		logic [7:0] cur_back;
		logic [7:0] cell_char;
		logic [7:0] cell_fore;
		logic [7:0] cell_back;
		logic       read_ok;
	} res_t;

endpackage
`default_nettype wire

### design/text_terminal_cell_writer_core.sv
`default_nettype none
// channel   | handshake        | fields
// command   | start / busy     | op char_code col row step_x step_y fore back
//           |                  | take_fore take_back scroll_lines
// result    | done (1 cycle)   | cursor_col cursor_row cur_fore cur_back
//           |                  | cell_char cell_fore cell_back read_ok
// config    | cfg_we           | cfg_idx cfg_data
//
// Most commands run in the back end as an execute step, then the result register,
// behind a queue entry; a busy back end holds commands in the queue.
// Clear walks every cell in use; scroll copies and refills. A two-entry queue
// buffers requests meanwhile. After reset all MAX_COLS*MAX_ROWS cells are cleared
// with busy high. Results are strobed; the receiver cannot stall.
module text_terminal_cell_writer_core import tcw_pkg::*; #(
	parameter int MAX_COLS = 80,
	parameter int MAX_ROWS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  op,
	input  wire logic [7:0]  char_code,
	input  wire logic [6:0]  col,
	input  wire logic [4:0]  row,
	input  wire logic signed [7:0] step_x,
	input  wire logic signed [7:0] step_y,
	input  wire logic [7:0]  fore,
	input  wire logic [7:0]  back,
	input  wire logic        take_fore,
	input  wire logic        take_back,
	input  wire logic [4:0]  scroll_lines,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [7:0]  cfg_data,
	output logic             done,
	output logic [6:0]       cursor_col,
	output logic [4:0]       cursor_row,
	output logic [7:0]       cur_fore,
	output logic [7:0]       cur_back,
	output logic [7:0]       cell_char,
	output logic [7:0]       cell_fore,
	output logic [7:0]       cell_back,
	output logic             read_ok
);

	cfg_t     cfg_q;
	cmd_t     req, cmd;
	bk_stat_t stat;
	logic     cmd_valid;
	res_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{RST_WIDTH, RST_HEIGHT, RST_DFORE, RST_DBACK};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WIDTH:  cfg_q.width_cols   <= cfg_data[6:0];
				REG_HEIGHT: cfg_q.height_rows  <= cfg_data[4:0];
				REG_DFORE:  cfg_q.default_fore <= cfg_data;
				REG_DBACK:  cfg_q.default_back <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		req              = '0;
		req.op           = op_t'(op);
		req.char_code    = char_code;
		req.col          = col;
		req.row          = row;
		req.step_x       = step_x;
		req.step_y       = step_y;
		req.fore         = fore;
		req.back         = back;
		req.take_fore    = take_fore;
		req.take_back    = take_back;
		req.scroll_lines = scroll_lines;
	end

	tcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.stat      (stat),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	tcw_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.stat      (stat),
		.res       (res)
	);

	assign done       = res.done;
	assign cursor_col = res.cursor_col;
	assign cursor_row = res.cursor_row;
	assign cur_fore   = res.cur_fore;
	assign cur_back   = res.cur_back;
	assign cell_char  = res.cell_char;
	assign cell_fore  = res.cell_fore;
	assign cell_back  = res.cell_back;
	assign read_ok    = res.read_ok;

endmodule
`default_nettype wire

### design/tcw_front.sv
`default_nettype none
module tcw_front import tcw_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire cmd_t     req,
	input  wire bk_stat_t stat,
	output logic          cmd_valid,
	output cmd_t          cmd
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;
	cmd_t       cls;

	// sort the byte of a put request once, here
	always_comb begin
		cls = req;
		unique case (req.char_code)
			CH_NL:   cls.kind = CK_NL;
			CH_CR:   cls.kind = CK_CR;
			CH_TAB:  cls.kind = CK_TAB;
			default: cls.kind = CK_GLYPH;
		endcase
	end

	assign busy      = (count_q == 2'd2) || stat.init;
	assign push      = start && !busy;
	assign cmd_valid = count_q != 2'd0;
	assign pop       = cmd_valid && stat.ready;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

### design/tcw_back.sv
`default_nettype none
module tcw_back import tcw_pkg::*; #(
	parameter int MAX_COLS = 80,
	parameter int MAX_ROWS = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	input  wire cfg_t cfg,
	output bk_stat_t  stat,
	output res_t      res
);

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int NW    = $clog2(CELLS + 1);
	localparam int PW    = $clog2(32 * MAX_COLS + 128);
	localparam logic [7:0] MAXC = 8'(MAX_COLS);
	localparam logic [5:0] MAXR = 6'(MAX_ROWS);
	localparam logic [NW-1:0] LAST_CELL = NW'(CELLS - 1);

	typedef enum logic [5:0] {
		ST_INIT  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SETUP = 6'b000100,
		ST_COPY  = 6'b001000,
		ST_FILL  = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	state_t        state_q;
	logic [23:0]   mem [CELLS];
	logic [23:0]   rd_q;
	logic [6:0]    cur_col_q;
	logic [4:0]    cur_row_q;
	logic [7:0]    act_fore_q, act_back_q;
	logic [NW-1:0] idx_q, end_q, gap_q, cells_q;
	logic          rd_ok_q;
	res_t          res_q;

	logic [7:0]        w;
	logic [5:0]        h;
	logic [PW-1:0]     pos_cur, pos_cmd;
	logic [7:0]        ncol;
	logic [5:0]        nrow;
	logic              glyph_wr;
	logic              pop;
	logic              we;
	logic [AW-1:0]     wa, ra;
	logic [23:0]       wd;
	logic signed [9:0] sx, sy;
	logic              cmd_in;

	always_comb begin
		if (cfg.width_cols == 7'd0) w = 8'd1;
		else if ({1'b0, cfg.width_cols} > MAXC) w = MAXC;
		else w = {1'b0, cfg.width_cols};
		if (cfg.height_rows == 5'd0) h = 6'd1;
		else if ({1'b0, cfg.height_rows} > MAXR) h = MAXR;
		else h = {1'b0, cfg.height_rows};
	end

	assign pop     = cmd_valid && (state_q == ST_IDLE);
	assign stat    = '{ready: state_q == ST_IDLE, init: state_q == ST_INIT};
	assign res     = res_q;
	assign pos_cur = PW'(cur_row_q) * PW'(w) + PW'(cur_col_q);
	assign pos_cmd = PW'(cmd.row) * PW'(w) + PW'(cmd.col);
	assign cmd_in  = ({1'b0, cmd.col} < w) && ({1'b0, cmd.row} < h);
	assign sx      = $signed({3'b000, cur_col_q}) + 10'(cmd.step_x);
	assign sy      = $signed({5'b00000, cur_row_q}) + 10'(cmd.step_y);

	// cursor advance for a put request
	always_comb begin
		ncol     = {1'b0, cur_col_q};
		nrow     = {1'b0, cur_row_q};
		glyph_wr = 1'b0;
		case (cmd.kind)
			CK_NL: begin
				ncol = 8'd0;
				nrow = nrow + 6'd1;
			end
			CK_CR:  ncol = 8'd0;
			CK_TAB: ncol = (ncol + TAB_STEP) & TAB_MASK;
			default: begin
				if (pos_cur < PW'(cells_q)) begin
					glyph_wr = 1'b1;
					ncol     = ncol + 8'd1;
				end
			end
		endcase
		if (ncol >= w) begin
			ncol = 8'd0;
			nrow = nrow + 6'd1;
		end
	end

	always_comb begin
		we = 1'b0;
		wa = AW'(idx_q);
		wd = {CH_SPACE, cfg.default_fore, cfg.default_back};
		ra = pos_cmd[AW-1:0];
		unique case (state_q)
			ST_INIT: begin
				we = 1'b1;
				wd = {CH_SPACE, RST_DFORE, RST_DBACK};
			end
			ST_IDLE: begin
				if (pop && cmd.op == OP_PUT && glyph_wr) begin
					we = 1'b1;
					wa = pos_cur[AW-1:0];
					wd = {cmd.char_code, act_fore_q, act_back_q};
				end
			end
			ST_COPY: begin
				// read runs one cell ahead of the write
				ra = AW'(idx_q + gap_q);
				if (idx_q != '0) begin
					we = 1'b1;
					wa = AW'(idx_q - NW'(1));
					wd = rd_q;
				end
			end
			ST_FILL: we = 1'b1;
			ST_SETUP, ST_RESP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			act_fore_q <= RST_DFORE;
			act_back_q <= RST_DBACK;
			idx_q      <= '0;
			end_q      <= '0;
			gap_q      <= '0;
			cells_q    <= '0;
			rd_ok_q    <= 1'b0;
			res_q      <= '0;
		end else begin
			cells_q    <= NW'(NW'(w) * NW'(h));
			res_q.done <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					idx_q <= idx_q + NW'(1);
					if (idx_q == LAST_CELL) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pop) begin
						rd_ok_q <= 1'b0;
						state_q <= ST_RESP;
						case (cmd.op)
							OP_PUT: begin
								cur_col_q <= ncol[6:0];
								cur_row_q <= nrow[4:0];
								if (nrow >= h) begin
									cur_row_q <= 5'(h - 6'd1);
									if (h == 6'd1) begin
										cur_col_q  <= '0;
										act_fore_q <= cfg.default_fore;
										act_back_q <= cfg.default_back;
										idx_q      <= '0;
										end_q      <= cells_q;
										state_q    <= ST_FILL;
									end else begin
										gap_q   <= NW'(w);
										state_q <= ST_SETUP;
									end
								end
							end
							OP_SET_CUR: begin
								if (cmd_in) begin
									cur_col_q <= cmd.col;
									cur_row_q <= cmd.row;
								end
							end
							OP_SHIFT_CUR: begin
								if (sx < 0) cur_col_q <= '0;
								else if (sx >= $signed({2'b00, w})) cur_col_q <= 7'(w - 8'd1);
								else cur_col_q <= sx[6:0];
								if (sy < 0) cur_row_q <= '0;
								else if (sy >= $signed({4'b0000, h})) cur_row_q <= 5'(h - 6'd1);
								else cur_row_q <= sy[4:0];
							end
							OP_SET_COL: begin
								if (cmd.take_fore) act_fore_q <= cmd.fore;
								if (cmd.take_back) act_back_q <= cmd.back;
							end
							OP_RST_COL: begin
								act_fore_q <= cfg.default_fore;
								act_back_q <= cfg.default_back;
							end
							OP_CLEAR, OP_SCROLL: begin
								if (cmd.op == OP_SCROLL && cmd.scroll_lines != 5'd0
										&& {1'b0, cmd.scroll_lines} < h) begin
									gap_q   <= NW'(NW'(cmd.scroll_lines) * NW'(w));
									state_q <= ST_SETUP;
								end else begin
									cur_col_q  <= '0;
									cur_row_q  <= '0;
									act_fore_q <= cfg.default_fore;
									act_back_q <= cfg.default_back;
									idx_q      <= '0;
									end_q      <= cells_q;
									state_q    <= ST_FILL;
								end
							end
							default: rd_ok_q <= cmd_in;
						endcase
					end
				end
				ST_SETUP: begin
					end_q   <= cells_q - gap_q;
					idx_q   <= '0;
					state_q <= ST_COPY;
				end
				ST_COPY: begin
					if (idx_q == end_q) begin
						end_q   <= cells_q;
						state_q <= ST_FILL;
					end else begin
						idx_q <= idx_q + NW'(1);
					end
				end
				ST_FILL: begin
					idx_q <= idx_q + NW'(1);
					if (idx_q == end_q - NW'(1)) state_q <= ST_RESP;
				end
				ST_RESP: begin
					res_q.done       <= 1'b1;
					res_q.cursor_col <= cur_col_q;
					res_q.cursor_row <= cur_row_q;
					res_q.cur_fore   <= act_fore_q;
					res_q.cur_back   <= act_back_q;
					res_q.cell_char  <= rd_ok_q ? rd_q[23:16] : 8'd0;
					res_q.cell_fore  <= rd_ok_q ? rd_q[15:8] : 8'd0;
					res_q.cell_back  <= rd_ok_q ? rd_q[7:0] : 8'd0;
					res_q.read_ok    <= rd_ok_q;
					rd_ok_q          <= 1'b0;
					state_q          <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### design/tcw_checker.sv
`default_nettype none
module tcw_checker #(
	parameter int MAX_COLS = 80,
	parameter int MAX_ROWS = 24
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       done,
	input wire logic [6:0] cursor_col,
	input wire logic [4:0] cursor_row,
	input wire logic [7:0] cell_char,
	input wire logic [7:0] cell_fore,
	input wire logic [7:0] cell_back,
	input wire logic       read_ok
);

	// each result passes through the idle (execute) state and then ST_RESP, so results never come back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back results");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({cursor_col, cursor_row, cell_char, cell_fore, cell_back,
			read_ok})) else $error("unknown bits in a result");

	a_cell_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !read_ok) |-> (cell_char == 8'd0 && cell_fore == 8'd0 && cell_back == 8'd0))
		else $error("cell fields set without a valid read");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(cursor_col) < MAX_COLS && 32'(cursor_row) < MAX_ROWS))
		else $error("cursor off the largest screen");

endmodule

bind text_terminal_cell_writer_core tcw_checker #(
	.MAX_COLS(MAX_COLS),
	.MAX_ROWS(MAX_ROWS)
) u_tcw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.done       (done),
	.cursor_col (cursor_col),
	.cursor_row (cursor_row),
	.cell_char  (cell_char),
	.cell_fore  (cell_fore),
	.cell_back  (cell_back),
	.read_ok    (read_ok)
);
`default_nettype wire

### tb/tb_top.sv
`default_nettype none
module tb_top;
	import tcw_pkg::*;

	localparam int GRID_COLS   = 80;
	localparam int GRID_ROWS   = 24;
	localparam int GRID_CELLS  = GRID_COLS * GRID_ROWS;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int RAND_ITEMS  = 1850;

	typedef struct {
		op_t               op;
		logic [7:0]        char_code;
		logic [6:0]        col;
		logic [4:0]        row;
		logic signed [7:0] step_x;
		logic signed [7:0] step_y;
		logic [7:0]        fore;
		logic [7:0]        back;
		logic              take_fore;
		logic              take_back;
		logic [4:0]        scroll_lines;
	} term_request_t;

	typedef struct {
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic [7:0] cur_fore;
		logic [7:0] cur_back;
		logic [7:0] cell_char;
		logic [7:0] cell_fore;
		logic [7:0] cell_back;
		logic       read_ok;
	} screen_result_t;

	class term_scoreboard;
		logic [7:0] glyphs [GRID_CELLS];
		logic [7:0] fg [GRID_CELLS];
		logic [7:0] bg [GRID_CELLS];
		int unsigned ccol, crow;
		logic [7:0] afore, aback;
		logic [6:0] width_reg;
		logic [4:0] height_reg;
		logic [7:0] dfore, dback;
		screen_result_t pending [$];
		int mismatches;
		int checked;

		function new();
			width_reg = RST_WIDTH;
			height_reg = RST_HEIGHT;
			dfore = RST_DFORE;
			dback = RST_DBACK;
			fill(0, GRID_CELLS);
			ccol = 0;
			crow = 0;
			afore = dfore;
			aback = dback;
			mismatches = 0;
			checked = 0;
		endfunction

		function int unsigned eff_w();
			if (width_reg < 1) return 1;
			if (width_reg > GRID_COLS) return GRID_COLS;
			return width_reg;
		endfunction

		function int unsigned eff_h();
			if (height_reg < 1) return 1;
			if (height_reg > GRID_ROWS) return GRID_ROWS;
			return height_reg;
		endfunction

		function void fill(int unsigned first, int unsigned count);
			for (int unsigned i = first; i < first + count; i++) begin
				glyphs[i] = CH_SPACE;
				fg[i] = dfore;
				bg[i] = dback;
			end
		endfunction

		function void clear_screen();
			fill(0, eff_w() * eff_h());
			ccol = 0;
			crow = 0;
			afore = dfore;
			aback = dback;
		endfunction

		function void scroll_up(int unsigned lines);
			int unsigned keep, gap;
			if (lines == 0 || lines >= eff_h()) begin
				clear_screen();
				return;
			end
			keep = (eff_h() - lines) * eff_w();
			gap = lines * eff_w();
			// forward copy is safe: source lies ahead of destination
			for (int unsigned i = 0; i < keep; i++) begin
				glyphs[i] = glyphs[i + gap];
				fg[i] = fg[i + gap];
				bg[i] = bg[i + gap];
			end
			fill(keep, gap);
		endfunction

		function void put_char(logic [7:0] c);
			int unsigned w, h, x, y, pos;
			w = eff_w();
			h = eff_h();
			x = ccol;
			y = crow;
			pos = y * w + x;
			if (c == CH_NL) begin
				x = 0;
				y++;
			end else if (c == CH_CR) begin
				x = 0;
			end else if (c == CH_TAB) begin
				x = (x + TAB_STEP) & ~32'(7);
			end else if (pos < w * h) begin
				glyphs[pos] = c;
				fg[pos] = afore;
				bg[pos] = aback;
				x++;
			end
			if (x >= w) begin
				x = 0;
				y++;
			end
			ccol = x & 'h7F;
			crow = y & 'h1F;
			if (y >= h) begin
				scroll_up(1);
				crow = h - 1;
			end
		endfunction

		function int unsigned clamp_axis(int v, int unsigned lim);
			if (v < 0) return 0;
			if (v >= int'(lim)) return lim - 1;
			return v;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] v);
			case (idx)
				REG_WIDTH:  width_reg = v[6:0];
				REG_HEIGHT: height_reg = v[4:0];
				REG_DFORE:  dfore = v;
				REG_DBACK:  dback = v;
				default: ;
			endcase
		endfunction

		function void note_request(term_request_t r);
			screen_result_t e;
			int unsigned w, h, p;
			w = eff_w();
			h = eff_h();
			e = '{default: '0};
			case (r.op)
				OP_PUT: put_char(r.char_code);
				OP_SET_CUR: begin
					if (r.col < w && r.row < h) begin
						ccol = r.col;
						crow = r.row;
					end
				end
				OP_SHIFT_CUR: begin
					ccol = clamp_axis(int'(ccol) + int'(r.step_x), w);
					crow = clamp_axis(int'(crow) + int'(r.step_y), h);
				end
				OP_SET_COL: begin
					if (r.take_fore) afore = r.fore;
					if (r.take_back) aback = r.back;
				end
				OP_RST_COL: begin
					afore = dfore;
					aback = dback;
				end
				OP_CLEAR: clear_screen();
				OP_SCROLL: scroll_up(r.scroll_lines);
				default: begin
					if (r.col < w && r.row < h) begin
						p = r.row * w + r.col;
						e.cell_char = glyphs[p];
						e.cell_fore = fg[p];
						e.cell_back = bg[p];
						e.read_ok = 1'b1;
					end
				end
			endcase
			e.cursor_col = ccol[6:0];
			e.cursor_row = crow[4:0];
			e.cur_fore = afore;
			e.cur_back = aback;
			pending.push_back(e);
		endfunction

		function void check_result(screen_result_t got);
			screen_result_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result: %p", got);
				return;
			end
			e = pending.pop_front();
			if (got.cursor_col !== e.cursor_col || got.cursor_row !== e.cursor_row ||
			    got.cur_fore !== e.cur_fore || got.cur_back !== e.cur_back ||
			    got.cell_char !== e.cell_char || got.cell_fore !== e.cell_fore ||
			    got.cell_back !== e.cell_back || got.read_ok !== e.read_ok) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch on result %0d", checked);
					$display("  expected %p", e);
					$display("  actual   %p", got);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] op = '0;
	logic [7:0] char_code = '0;
	logic [6:0] col = '0;
	logic [4:0] row = '0;
	logic signed [7:0] step_x = '0;
	logic signed [7:0] step_y = '0;
	logic [7:0] fore = '0;
	logic [7:0] back = '0;
	logic take_fore = 1'b0;
	logic take_back = 1'b0;
	logic [4:0] scroll_lines = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [7:0] cfg_data = '0;
	logic done;
	logic [6:0] cursor_col;
	logic [4:0] cursor_row;
	logic [7:0] cur_fore, cur_back, cell_char, cell_fore, cell_back;
	logic read_ok;

	term_scoreboard sb;
	int cycles = 0;
	int issued = 0;
	int idle_pct = 24;
	int setups = 0;

	text_terminal_cell_writer_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .char_code(char_code), .col(col), .row(row),
		.step_x(step_x), .step_y(step_y), .fore(fore), .back(back),
		.take_fore(take_fore), .take_back(take_back), .scroll_lines(scroll_lines),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.done(done), .cursor_col(cursor_col), .cursor_row(cursor_row),
		.cur_fore(cur_fore), .cur_back(cur_back), .cell_char(cell_char),
		.cell_fore(cell_fore), .cell_back(cell_back), .read_ok(read_ok)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && done === 1'b1 && sb != null)
			sb.check_result('{cursor_col, cursor_row, cur_fore, cur_back,
			                  cell_char, cell_fore, cell_back, read_ok});
	end

	function automatic term_request_t blank_request(op_t o);
		term_request_t r;
		r.op = o;
		r.char_code = 8'($urandom);
		r.col = 7'($urandom);
		r.row = 5'($urandom);
		r.step_x = 8'($urandom);
		r.step_y = 8'($urandom);
		r.fore = 8'($urandom);
		r.back = 8'($urandom);
		r.take_fore = 1'($urandom);
		r.take_back = 1'($urandom);
		r.scroll_lines = 5'($urandom);
		return r;
	endfunction

	// called after a rising edge; returns after acceptance and any idle gap
	task automatic issue(input term_request_t r);
		start <= 1'b1;
		op <= r.op;
		char_code <= r.char_code;
		col <= r.col;
		row <= r.row;
		step_x <= r.step_x;
		step_y <= r.step_y;
		fore <= r.fore;
		back <= r.back;
		take_fore <= r.take_fore;
		take_back <= r.take_back;
		scroll_lines <= r.scroll_lines;
		do @(negedge clk); while (busy !== 1'b0);
		@(posedge clk);
		sb.note_request(r);
		issued++;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		do @(negedge clk); while (busy !== 1'b0);
		@(posedge clk);
	endtask

	task automatic setup_screen(input logic [7:0] w, h, df, db, input bit wipe);
		logic [7:0] vals [4];
		vals = '{w, h, df, db};
		settle();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= i[1:0];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(i[1:0], vals[i]);
		end
		cfg_we <= 1'b0;
		setups++;
		if (wipe) issue(blank_request(OP_CLEAR));
	endtask

	function automatic term_request_t random_request();
		term_request_t r;
		int unsigned sel, w, h;
		w = sb.eff_w();
		h = sb.eff_h();
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			r = blank_request(OP_PUT);
			sel = $urandom_range(0, 99);
			if (sel < 8) r.char_code = CH_NL;
			else if (sel < 12) r.char_code = CH_CR;
			else if (sel < 17) r.char_code = CH_TAB;
			else if (sel < 80) r.char_code = 8'($urandom_range(33, 126));
		end else if (sel < 62) begin
			r = blank_request(OP_SET_CUR);
			if ($urandom_range(0, 3) != 0) begin
				r.col = 7'($urandom_range(0, w + 1));
				r.row = 5'($urandom_range(0, h + 1));
			end
		end else if (sel < 68) begin
			r = blank_request(OP_SHIFT_CUR);
			if ($urandom_range(0, 2) != 0) begin
				r.step_x = $signed(8'($urandom_range(0, 20))) - 8'sd10;
				r.step_y = $signed(8'($urandom_range(0, 6))) - 8'sd3;
			end
		end else if (sel < 74) r = blank_request(OP_SET_COL);
		else if (sel < 77) r = blank_request(OP_RST_COL);
		else if (sel < 79) r = blank_request(OP_CLEAR);
		else if (sel < 82) begin
			r = blank_request(OP_SCROLL);
			if ($urandom_range(0, 1)) r.scroll_lines = 5'($urandom_range(1, 3));
		end else begin
			r = blank_request(OP_READ);
			if ($urandom_range(0, 5) != 0) begin
				r.col = 7'($urandom_range(0, w));
				r.row = 5'($urandom_range(0, h));
			end
		end
		return r;
	endfunction

	initial begin
		term_request_t r;
		logic [7:0] dir_chars [5];
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		do @(negedge clk); while (busy !== 1'b0);
		@(posedge clk);

		// directed: field extremes, control characters, every command
		dir_chars = '{8'd0, 8'd255, CH_TAB, CH_NL, CH_CR};
		foreach (dir_chars[i]) begin
			r = blank_request(OP_PUT);
			r.char_code = dir_chars[i];
			issue(r);
		end
		r = blank_request(OP_SET_CUR); r.col = 39; r.row = 9; issue(r);
		r = blank_request(OP_PUT); r.char_code = 8'h41; issue(r);
		r = blank_request(OP_SET_CUR); r.col = 127; r.row = 31; issue(r);
		r = blank_request(OP_SET_CUR); r.col = 0; r.row = 9; issue(r);
		r = blank_request(OP_PUT); r.char_code = CH_NL; issue(r);
		r = blank_request(OP_SHIFT_CUR); r.step_x = 127; r.step_y = 127; issue(r);
		r = blank_request(OP_SHIFT_CUR); r.step_x = -128; r.step_y = -128; issue(r);
		r = blank_request(OP_SET_COL);
		r.fore = 255; r.back = 255; r.take_fore = 1; r.take_back = 1; issue(r);
		r = blank_request(OP_SET_COL);
		r.fore = 0; r.back = 0; r.take_fore = 1; r.take_back = 0; issue(r);
		r = blank_request(OP_SET_COL); r.take_fore = 0; r.take_back = 1; issue(r);
		r = blank_request(OP_PUT); r.char_code = 8'h7E; issue(r);
		r = blank_request(OP_READ); r.col = 0; r.row = 0; issue(r);
		r = blank_request(OP_READ); r.col = 127; r.row = 31; issue(r);
		issue(blank_request(OP_RST_COL));
		r = blank_request(OP_SCROLL); r.scroll_lines = 1; issue(r);
		r = blank_request(OP_SCROLL); r.scroll_lines = 31; issue(r);
		r = blank_request(OP_SCROLL); r.scroll_lines = 0; issue(r);
		issue(blank_request(OP_CLEAR));

		// single-cell screen: every newline or wrap clears
		setup_screen(8'd1, 8'd1, 8'd0, 8'd0, 1'b1);
		for (int i = 0; i < 12; i++) issue(random_request());
		setup_screen(8'd80, 8'd24, 8'd255, 8'd255, 1'b1);
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == RAND_ITEMS / 3) idle_pct = 59;
			if (i == 2 * RAND_ITEMS / 3) idle_pct = 0;
			if (i > 0 && i % 170 == 0) begin
				case ((i / 170) % 5)
					0: setup_screen(8'd0, 8'd0, 8'($urandom), 8'($urandom), 1'b1);
					1: setup_screen(8'd127, 8'd31, 8'($urandom), 8'($urandom), 1'b0);
					2: setup_screen(8'd3, 8'd2, 8'($urandom), 8'($urandom), 1'b1);
					default: setup_screen(8'($urandom_range(0, 127)),
					                      8'($urandom_range(0, 31)), 8'($urandom),
					                      8'($urandom), 1'($urandom));
				endcase
			end
			issue(random_request());
		end
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d commands issued across %0d screen setups, %0d results checked",
		         issued, setups, sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire

### text_terminal_cell_writer_core.f
design/tcw_pkg.sv
design/tcw_front.sv
design/tcw_back.sv
design/text_terminal_cell_writer_core.sv
design/tcw_checker.sv
tb/tb_top.sv
